### src/binary_morphology_filter_top_assert.svh
// Assertion macros used by the binary morphology filter checker.
`ifndef BINARY_MORPHOLOGY_FILTER_TOP_ASSERT_SVH
`define BINARY_MORPHOLOGY_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define BMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("binary morphology filter check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define BMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("binary morphology filter check failed");

`endif

### src/bmf_pkg.sv
// Types and constants shared by the binary morphology filter modules.
`timescale 1ns / 1ps
`default_nettype none

package bmf_pkg;

    // Width of the configuration data bus, which also carries the frame sizes.
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 8;

    // Pixel value that marks an object.
    localparam logic [PIX_W-1:0] PIX_OBJ = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BG  = 8'd0;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // Input transaction kinds.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        MODE_ERODE  = 2'd0,
        MODE_DILATE = 2'd1,
        MODE_OPEN   = 2'd2,
        MODE_CLOSE  = 2'd3
    } mode_t;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             end_of_row;
        logic             end_of_frame;
    } out_t;

    // Result of one slot of a filter stage.
    typedef struct packed {
        logic             got;
        logic [PIX_W-1:0] val;
        logic             eor;
        logic             eof;
    } stage_res_t;

    // One step offered to a filter stage.
    typedef struct packed {
        logic             en;
        logic             has_pixel;
        logic [PIX_W-1:0] x;
    } stage_step_t;

endpackage

`default_nettype wire

### src/binary_morphology_filter_top.sv
// Top level of the streaming 3x3 binary morphology filter.
//
//   Channel  Direction  Handshake              Payload
//   s_       in         s_valid / s_ready      op, pixel_in
//   m_       out        m_valid / m_ready      pixel_out, end_of_row, end_of_frame
//   cfg_     in         cfg_wr_en (no wait)    cfg_index, cfg_wdata
//
// One input transaction per cycle while s_ready is high; results pass the stage-one and output registers.
// Each stage has one line buffer RAM, read every cycle and written on each active step.
// A stage emits its first pixel width+1 pixels into a frame and needs width+1
// flush transactions to push out its last row.
// Reset is synchronous; line buffer contents are not cleared and need no pass.
// A stalled output holds its result while one more transaction is taken in.
`timescale 1ns / 1ps
`default_nettype none

module binary_morphology_filter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bmf_pkg::in_t                  s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output bmf_pkg::out_t                      m_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bmf_pkg::CFG_DIM_W-1:0] cfg_wdata
);
    import bmf_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    // Zero means one; above the maximum saturates.
    function automatic logic [CFG_DIM_W-1:0] sat_dim(input logic [CFG_DIM_W-1:0] raw,
                                                     input int unsigned lim);
        logic [CFG_DIM_W-1:0] r;
        r = raw;
        if (raw == '0) begin
            r = CFG_DIM_W'(1);
        end else if (32'(raw) > lim) begin
            r = CFG_DIM_W'(lim);
        end
        return r;
    endfunction

    mode_t            mode_reg;
    logic [CNT_W-1:0] eff_w_reg;
    logic [ROW_W-1:0] eff_h_reg;
    logic             restart;

    logic             tok_valid_reg;
    stage_res_t       tok_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;

    logic             out_free, s_fire, tok_fire, two_stage;
    stage_step_t      step1, step2;
    stage_res_t       res1, res2, res_sel;

    // Configuration registers; a valid write restarts both stages.
    assign restart = cfg_wr_en && (cfg_index == REG_FILTER_MODE ||
                                   cfg_index == REG_FRAME_WIDTH ||
                                   cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ERODE;
            eff_w_reg <= CNT_W'(sat_dim(11'd640, MAX_WIDTH));
            eff_h_reg <= ROW_W'(sat_dim(11'd480, MAX_HEIGHT));
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FILTER_MODE:  mode_reg  <= mode_t'(cfg_wdata[1:0]);
                REG_FRAME_WIDTH:  eff_w_reg <= CNT_W'(sat_dim(cfg_wdata, MAX_WIDTH));
                REG_FRAME_HEIGHT: eff_h_reg <= ROW_W'(sat_dim(cfg_wdata, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // Handshake: the output register and the stage-one register part the sides.
    assign out_free  = !m_valid_reg || m_ready;
    assign tok_fire  = tok_valid_reg && out_free;
    assign s_ready   = !tok_valid_reg || out_free;
    assign s_fire    = s_valid && s_ready;
    assign two_stage = (mode_reg == MODE_OPEN) || (mode_reg == MODE_CLOSE);

    // Stage one works on the accepted transaction.
    always_comb begin
        step1.en        = s_fire;
        step1.has_pixel = (s_data.op == OP_PIXEL);
        step1.x         = s_data.pixel_in;
    end

    bmf_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stage1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .dilate  ((mode_reg == MODE_DILATE) || (mode_reg == MODE_CLOSE)),
        .eff_w   (eff_w_reg),
        .eff_h   (eff_h_reg),
        .step    (step1),
        .res     (res1)
    );

    // Stage-one result register: one entry per accepted transaction.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            tok_reg <= res1;
        end
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else if (s_fire) begin
            tok_valid_reg <= 1'b1;
        end else if (tok_fire) begin
            tok_valid_reg <= 1'b0;
        end
    end

    // Stage two runs only in open and close, once per stage-one step.
    always_comb begin
        step2.en        = tok_fire && two_stage;
        step2.has_pixel = tok_reg.got;
        step2.x         = tok_reg.val;
    end

    bmf_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stage2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .dilate  (mode_reg == MODE_OPEN),
        .eff_w   (eff_w_reg),
        .eff_h   (eff_h_reg),
        .step    (step2),
        .res     (res2)
    );

    assign res_sel = two_stage ? res2 : tok_reg;

    // Output register.
    always_ff @(posedge aclk) begin
        if (tok_fire) begin
            m_data_reg.pixel_out    <= res_sel.val;
            m_data_reg.end_of_row   <= res_sel.eor;
            m_data_reg.end_of_frame <= res_sel.eof;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tok_fire) begin
            m_valid_reg <= res_sel.got;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### src/bmf_ram.sv
// Generic simple dual-port RAM with registered read (read-first).
`timescale 1ns / 1ps
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/bmf_stage.sv
// One 3x3 morphology stage: two-row line buffer, window and position counters.
`timescale 1ns / 1ps
`default_nettype none

module bmf_stage #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                restart,
    input  wire logic                                dilate,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      eff_w,
    input  wire logic [$clog2(MAX_HEIGHT+2)-1:0]     eff_h,
    input  wire bmf_pkg::stage_step_t                step,
    output bmf_pkg::stage_res_t                      res
);
    import bmf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PIX_W-1:0]  win_reg [9];
    logic [PIX_W-1:0]  win_next [9];
    logic              byp_reg;
    logic [2*PIX_W-1:0] byp_data_reg;

    logic [2*PIX_W-1:0] ram_q;
    logic [2*PIX_W-1:0] line_q;
    logic [2*PIX_W-1:0] line_wdata;
    logic [PIX_W-1:0]   pix_a, pix_b, xin;

    logic              drain, act, col_nz, emit, last_col;
    logic [CNT_W-1:0]  col_ext, col_inc, ocol;
    logic [ROW_W-1:0]  orow;
    logic              up, dn, lf, rt, hit, eor, eof;

    // Slot position and whether this step does any work.
    always_comb begin
        col_ext  = CNT_W'(col_reg);
        col_inc  = col_ext + CNT_W'(1);
        last_col = (col_inc == eff_w);
        drain    = (row_reg >= eff_h);
        act      = step.en && (step.has_pixel || drain);
        xin      = drain ? PIX_BG : step.x;
        col_nz   = (col_reg != '0);
        emit     = act && (col_nz ? (row_reg != '0) : (row_reg > ROW_W'(1)));
        orow     = col_nz ? (row_reg - ROW_W'(1)) : (row_reg - ROW_W'(2));
        ocol     = col_nz ? (col_ext - CNT_W'(1)) : (eff_w - CNT_W'(1));
    end

    // Line buffer read data, with bypass for a write to the address being read.
    always_comb begin
        line_q     = byp_reg ? byp_data_reg : ram_q;
        pix_a      = line_q[PIX_W-1:0];
        pix_b      = line_q[2*PIX_W-1:PIX_W];
        line_wdata = {pix_a, xin};
    end

    // Window shifts left and takes the new column: oldest row on top.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = pix_b;
        win_next[5] = pix_a;
        win_next[8] = xin;
    end

    // Neighbor checks on the shifted window.
    always_comb begin
        up  = (orow != '0);
        dn  = ((orow + ROW_W'(1)) < eff_h);
        lf  = (ocol != '0);
        rt  = ((ocol + CNT_W'(1)) < eff_w);
        eor = (ocol == (eff_w - CNT_W'(1)));
        eof = eor && (orow == (eff_h - ROW_W'(1)));
        if (dilate) begin
            hit = (up && win_next[1] == PIX_OBJ) || (dn && win_next[7] == PIX_OBJ) ||
                  (lf && win_next[3] == PIX_OBJ) || (rt && win_next[5] == PIX_OBJ) ||
                  (up && lf && win_next[0] == PIX_OBJ) ||
                  (up && rt && win_next[2] == PIX_OBJ) ||
                  (dn && lf && win_next[6] == PIX_OBJ) ||
                  (dn && rt && win_next[8] == PIX_OBJ);
        end else begin
            hit = (up && win_next[1] == PIX_BG) || (dn && win_next[7] == PIX_BG) ||
                  (lf && win_next[3] == PIX_BG) || (rt && win_next[5] == PIX_BG);
        end
        res.got = emit;
        res.val = hit ? (dilate ? PIX_OBJ : PIX_BG) : win_next[4];
        res.eor = eor;
        res.eof = eof;
    end

    // Next slot position; the end of frame starts the next frame.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (act) begin
            priority if (emit && eof) begin
                col_next = '0;
                row_next = '0;
            end else if (last_col) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = ADDR_W'(col_inc);
            end
        end else begin
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    // Line buffer: both delayed rows of one column in one entry.
    bmf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (act),
        .waddr (col_reg),
        .wdata (line_wdata),
        .raddr (col_next),
        .rdata (ram_q)
    );

    // Position counters and bypass control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            byp_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            byp_reg <= act && (col_next == col_reg);
        end
    end

    // Window and bypass data.
    always_ff @(posedge aclk) begin
        byp_data_reg <= line_wdata;
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (act) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

`default_nettype wire

### src/bmf_checker.sv
// Port-level checks for the binary morphology filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "binary_morphology_filter_top_assert.svh"

module bmf_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire bmf_pkg::out_t m_data
);
    import bmf_pkg::*;

    // A stalled result transaction holds its payload.
    `BMF_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // The last pixel of a frame is also the last of its row.
    `BMF_ASSERT_IMP(a_eof_eor, m_valid && m_data.end_of_frame, m_data.end_of_row)

    // With the output empty the input side must be open.
    `BMF_ASSERT_IMP(a_ready_when_empty, !m_valid, s_ready)

    // The input side closes only behind a stalled result.
    `BMF_ASSERT_IMP(a_stall_cause, !s_ready, m_valid && !m_ready)

endmodule

bind binary_morphology_filter_top bmf_checker u_bmf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
